// ===== design/midi_clock_bar_note_follower_top_assert.svh =====
// Assertion macros for the bar note follower.
`ifndef MIDI_CLOCK_BAR_NOTE_FOLLOWER_TOP_ASSERT_SVH
`define MIDI_CLOCK_BAR_NOTE_FOLLOWER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define MCBNF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle assertion failed");

`define MCBNF_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle assertion failed");

`else

`define MCBNF_ASSERT_IMP(lbl, clk, rst, ante, cons)

`define MCBNF_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== design/mcbnf_pkg.sv =====
package mcbnf_pkg;

   localparam int COUNT_BITS_DEF    = 24;
   localparam int TICKS_PER_QUARTER = 24;
   localparam int BAR_TICKS         = 4 * TICKS_PER_QUARTER;
   localparam int SIXTEENTH_TICKS   = TICKS_PER_QUARTER / 4;
   // note-off window: 1 <= into and into*10 < bar length
   localparam int OFF_LAST_TICK     = (BAR_TICKS - 1) / 10;

   localparam logic [2:0] OP_CLOCK    = 3'd0;
   localparam logic [2:0] OP_START    = 3'd1;
   localparam logic [2:0] OP_STOP     = 3'd2;
   localparam logic [2:0] OP_CONTINUE = 3'd3;
   localparam logic [2:0] OP_SONGPOS  = 3'd4;

   localparam logic [1:0] CSR_ADVANCE  = 2'd0;
   localparam logic [1:0] CSR_CHANNEL  = 2'd1;
   localparam logic [1:0] CSR_NOTE     = 2'd2;
   localparam logic [1:0] CSR_VELOCITY = 2'd3;

   localparam logic [3:0] ADVANCE_RST  = 4'd2;
   localparam logic [3:0] CHANNEL_RST  = 4'd0;
   localparam logic [6:0] NOTE_RST     = 7'd60;
   localparam logic [6:0] VELOCITY_RST = 7'd100;

   typedef struct packed {
      logic        note_off;
      logic        note_on;
      logic [19:0] quarters;
      logic [21:0] position;
      logic        running;
      logic [31:0] clocks;
   } result_type;

endpackage

// ===== design/mcbnf_if.sv =====
interface mcbnf_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  opcode;
   logic [13:0] song_position;

   modport source (output valid, output opcode, output song_position, input ready);
   modport sink (input valid, input opcode, input song_position, output ready);
endinterface

interface mcbnf_rsp_if;
   logic        valid;
   logic        ready;
   logic        note_off_sent;
   logic        note_on_sent;
   logic [3:0]  out_channel;
   logic [6:0]  out_note;
   logic [6:0]  out_velocity;
   logic [19:0] beat_quarter_count;
   logic [21:0] position_sixteenths;
   logic        is_running;
   logic [31:0] clocks_received;

   modport source (output valid, output note_off_sent, output note_on_sent,
                   output out_channel, output out_note, output out_velocity,
                   output beat_quarter_count, output position_sixteenths,
                   output is_running, output clocks_received, input ready);
   modport sink (input valid, input note_off_sent, input note_on_sent,
                 input out_channel, input out_note, input out_velocity,
                 input beat_quarter_count, input position_sixteenths,
                 input is_running, input clocks_received, output ready);
endinterface

interface mcbnf_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [6:0] wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink (input valid, input index, input wdata, output ready);
endinterface

// ===== design/mcbnf_tracker.sv =====
`include "midi_clock_bar_note_follower_top_assert.svh"

module mcbnf_tracker #(
   parameter int COUNT_BITS = mcbnf_pkg::COUNT_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [2:0]             opcode,
   input  logic [13:0]            song_position,
   input  logic [3:0]             advance,
   output mcbnf_pkg::result_type  result
);

   // tick/96 and tick/6 are kept as running quotient/remainder pairs
   localparam int BAR_BITS = COUNT_BITS - 6;
   localparam int POS_BITS = COUNT_BITS - 2;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   logic                       running_ff, running_in;
   logic [COUNT_BITS-1:0]      tick_ff, tick_in;
   logic [BAR_BITS-1:0]        bar_ff, bar_in;
   logic [6:0]                 into_ff, into_in;
   logic [2:0]                 sub_ff, sub_in;
   logic [POS_BITS-1:0]        pos_ff, pos_in;
   logic signed [BAR_BITS:0]   last_ff, last_in, last_pre;
   logic                       active_ff, active_in, active_pre;
   logic [31:0]                clocks_ff, clocks_in;

   logic                       check;
   logic                       stop_off;
   logic                       back;
   logic [BAR_BITS-1:0]        sp_bar;
   logic [3:0]                 adv_eff;
   logic                       first;
   logic [BAR_BITS:0]          bar_next;
   logic [BAR_BITS:0]          target;
   logic                       later;
   logic                       lead;
   logic                       emit;
   logic                       off_bar;

   assign sp_bar = BAR_BITS'(song_position[13:4]);
   assign back   = ({1'b0, tick_in} + (COUNT_BITS+1)'(mcbnf_pkg::TICKS_PER_QUARTER / 2))
                   < {1'b0, tick_ff};

   always_comb begin
      running_in = running_ff;
      tick_in    = tick_ff;
      bar_in     = bar_ff;
      into_in    = into_ff;
      sub_in     = sub_ff;
      pos_in     = pos_ff;
      last_pre   = last_ff;
      active_pre = active_ff;
      clocks_in  = clocks_ff;
      check      = 1'b0;
      stop_off   = 1'b0;
      case (opcode)
         mcbnf_pkg::OP_CLOCK: begin
            clocks_in = clocks_ff + 32'd1;
            if (running_ff) begin
               check = 1'b1;
               if (tick_ff != COUNT_MAX) begin
                  tick_in = tick_ff + COUNT_BITS'(1);
                  if (into_ff == 7'(mcbnf_pkg::BAR_TICKS - 1)) begin
                     into_in = '0;
                     bar_in  = bar_ff + BAR_BITS'(1);
                  end else begin
                     into_in = into_ff + 7'd1;
                  end
                  if (sub_ff == 3'(mcbnf_pkg::SIXTEENTH_TICKS - 1)) begin
                     sub_in = '0;
                     pos_in = pos_ff + POS_BITS'(1);
                  end else begin
                     sub_in = sub_ff + 3'd1;
                  end
               end
            end
         end
         mcbnf_pkg::OP_START: begin
            if (!running_ff) begin
               tick_in    = '0;
               bar_in     = '0;
               into_in    = '0;
               sub_in     = '0;
               pos_in     = '0;
               last_pre   = '1;
               running_in = 1'b1;
            end
         end
         mcbnf_pkg::OP_STOP: begin
            if (running_ff) begin
               stop_off   = active_ff;
               active_pre = 1'b0;
               tick_in    = '0;
               bar_in     = '0;
               into_in    = '0;
               sub_in     = '0;
               pos_in     = '0;
               last_pre   = '1;
               running_in = 1'b0;
            end
         end
         mcbnf_pkg::OP_CONTINUE: begin
            if (!running_ff) begin
               last_pre   = $signed({1'b0, bar_ff}) - 2'sd1;
               running_in = 1'b1;
            end
         end
         mcbnf_pkg::OP_SONGPOS: begin
            // six ticks per sixteenth, sixteen sixteenths per bar
            tick_in = COUNT_BITS'({song_position, 2'b00}) + COUNT_BITS'({song_position, 1'b0});
            bar_in  = sp_bar;
            into_in = 7'({song_position[3:0], 2'b00}) + 7'({song_position[3:0], 1'b0});
            sub_in  = '0;
            pos_in  = POS_BITS'(song_position);
            if (!running_ff || back) begin
               // half a bar is eight sixteenths
               if (song_position[3]) begin
                  last_pre = $signed({1'b0, sp_bar});
               end else begin
                  last_pre = $signed({1'b0, sp_bar}) - 2'sd1;
               end
            end
            check = running_ff;
         end
         default: begin
         end
      endcase
   end

   assign adv_eff  = (advance == 4'd0) ? 4'd1 : advance;
   assign first    = (bar_in == '0) && last_pre[BAR_BITS]
                     && (into_in < 7'(mcbnf_pkg::TICKS_PER_QUARTER));
   assign bar_next = {1'b0, bar_in} + (BAR_BITS+1)'(1);
   assign later    = $signed({1'b0, bar_next}) > $signed({last_pre[BAR_BITS], last_pre});
   assign lead     = into_in >= (7'(mcbnf_pkg::BAR_TICKS) - {3'b000, adv_eff});
   assign emit     = check && (first || (later && lead));
   assign target   = first ? {1'b0, bar_in} : bar_next;
   assign off_bar  = check && active_ff && (into_in != 7'd0)
                     && (into_in <= 7'(mcbnf_pkg::OFF_LAST_TICK));

   assign last_in   = emit ? $signed(target) : last_pre;
   assign active_in = emit || (active_pre && !off_bar);

   always_comb begin
      result          = '0;
      result.note_off = off_bar || stop_off;
      result.note_on  = emit;
      result.quarters = emit ? 20'({target, 2'b00}) : 20'd0;
      result.position = 22'(pos_in);
      result.running  = running_in;
      result.clocks   = clocks_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         tick_ff    <= '0;
         bar_ff     <= '0;
         into_ff    <= '0;
         sub_ff     <= '0;
         pos_ff     <= '0;
         last_ff    <= '1;
         active_ff  <= 1'b0;
         clocks_ff  <= '0;
      end else if (accept) begin
         running_ff <= running_in;
         tick_ff    <= tick_in;
         bar_ff     <= bar_in;
         into_ff    <= into_in;
         sub_ff     <= sub_in;
         pos_ff     <= pos_in;
         last_ff    <= last_in;
         active_ff  <= active_in;
         clocks_ff  <= clocks_in;
      end
   end

   `MCBNF_ASSERT_IMP(a_remainders_in_range, clock, reset, 1'b1,
                     (into_ff < 7'(mcbnf_pkg::BAR_TICKS))
                     && (sub_ff < 3'(mcbnf_pkg::SIXTEENTH_TICKS)))
   `MCBNF_ASSERT_NXT(a_note_on_arms, clock, reset, accept && result.note_on,
                     active_ff && running_ff)
   `MCBNF_ASSERT_IMP(a_stopped_clock_silent, clock, reset,
                     accept && !running_ff && (opcode == mcbnf_pkg::OP_CLOCK),
                     !result.note_on && !result.note_off)
   `MCBNF_ASSERT_NXT(a_stop_rewinds, clock, reset,
                     accept && running_ff && (opcode == mcbnf_pkg::OP_STOP),
                     !running_ff && !active_ff && (tick_ff == '0) && last_ff[BAR_BITS])

endmodule

// ===== design/midi_clock_bar_note_follower_top.sv =====
// MIDI clock follower in slave mode. Each request transaction carries one transport
// event (clock, start, stop, continue, song position); each one yields exactly one
// response transaction, saying whether a note-off and/or the bar note-on is to be
// sent, with channel, note, velocity, the bar index times four, the position in
// sixteenths, the running flag and the wrapping clock total. The state update and the
// response are computed in a single pass and land in the response register, so a new
// event is taken in every cycle unless that register is full and not being drained.
// Settings are written through the CSR channel, which is always ready; write them only
// while no event is in flight.
module midi_clock_bar_note_follower_top #(
   parameter int COUNT_BITS = mcbnf_pkg::COUNT_BITS_DEF
) (
   input logic         clock,
   input logic         reset,
   mcbnf_req_if.sink   req_if,
   mcbnf_rsp_if.source rsp_if,
   mcbnf_csr_if.sink   csr_if
);

   logic [3:0] adv_ff;
   logic [3:0] chan_ff;
   logic [6:0] note_ff;
   logic [6:0] vel_ff;

   logic                  accept;
   mcbnf_pkg::result_type result;

   logic        rsp_valid_ff;
   logic        off_ff;
   logic        on_ff;
   logic [3:0]  rsp_chan_ff;
   logic [6:0]  rsp_note_ff;
   logic [6:0]  rsp_vel_ff;
   logic [19:0] quarters_ff;
   logic [21:0] position_ff;
   logic        running_ff;
   logic [31:0] clocks_ff;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         adv_ff  <= mcbnf_pkg::ADVANCE_RST;
         chan_ff <= mcbnf_pkg::CHANNEL_RST;
         note_ff <= mcbnf_pkg::NOTE_RST;
         vel_ff  <= mcbnf_pkg::VELOCITY_RST;
      end else if (csr_if.valid) begin
         unique case (csr_if.index)
            mcbnf_pkg::CSR_ADVANCE:  adv_ff  <= csr_if.wdata[3:0];
            mcbnf_pkg::CSR_CHANNEL:  chan_ff <= csr_if.wdata[3:0];
            mcbnf_pkg::CSR_NOTE:     note_ff <= csr_if.wdata;
            mcbnf_pkg::CSR_VELOCITY: vel_ff  <= csr_if.wdata;
            default: begin
            end
         endcase
      end
   end

   // response register frees up in the same cycle it is drained
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;

   mcbnf_tracker #(
      .COUNT_BITS (COUNT_BITS)
   ) u_tracker (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .opcode        (req_if.opcode),
      .song_position (req_if.song_position),
      .advance       (adv_ff),
      .result        (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         off_ff      <= result.note_off;
         on_ff       <= result.note_on;
         rsp_chan_ff <= chan_ff;
         rsp_note_ff <= note_ff;
         rsp_vel_ff  <= result.note_on ? vel_ff : 7'd0;
         quarters_ff <= result.quarters;
         position_ff <= result.position;
         running_ff  <= result.running;
         clocks_ff   <= result.clocks;
      end
   end

   assign rsp_if.valid               = rsp_valid_ff;
   assign rsp_if.note_off_sent       = off_ff;
   assign rsp_if.note_on_sent        = on_ff;
   assign rsp_if.out_channel         = rsp_chan_ff;
   assign rsp_if.out_note            = rsp_note_ff;
   assign rsp_if.out_velocity        = rsp_vel_ff;
   assign rsp_if.beat_quarter_count  = quarters_ff;
   assign rsp_if.position_sixteenths = position_ff;
   assign rsp_if.is_running          = running_ff;
   assign rsp_if.clocks_received     = clocks_ff;

endmodule

// ===== tb/tb.sv =====
module tb;

   // opcodes the block has no name for; they must leave the state alone
   localparam logic [2:0] OP_SPARE_LO = 3'd5;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;
   localparam longint     COUNT_MAX   = (longint'(1) << mcbnf_pkg::COUNT_BITS_DEF) - 1;
   localparam int         SONGPOS_MAX = 16383;

   typedef struct packed {
      logic        note_off;
      logic        note_on;
      logic [3:0]  channel;
      logic [6:0]  note;
      logic [6:0]  velocity;
      logic [19:0] quarters;
      logic [21:0] position;
      logic        running;
      logic [31:0] clocks;
   } note_report_type;

   // one transport event; where pinned is set the fields after it are the
   // expected report, typed in by hand
   typedef struct packed {
      logic [2:0]  op;
      logic [13:0] sp;
      logic        pinned;
      logic        off;
      logic        on;
      logic [6:0]  vel;
      logic [19:0] quarters;
      logic [21:0] position;
      logic        running;
      logic [31:0] clocks;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   always #4 clock = ~clock;

   mcbnf_req_if req_if ();
   mcbnf_rsp_if rsp_if ();
   mcbnf_csr_if csr_if ();

   midi_clock_bar_note_follower_top u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // follower state as the block should hold it
   logic                                 fl_running;
   logic [mcbnf_pkg::COUNT_BITS_DEF-1:0] fl_ticks;
   int                                   fl_last_bar;
   logic                                 fl_sounding;
   logic [31:0]                          fl_clocks;
   logic [3:0]                           cfg_advance;
   logic [3:0]                           cfg_channel;
   logic [6:0]                           cfg_note;
   logic [6:0]                           cfg_velocity;

   note_report_type expected_reports [$];
   stim_row_type    pinned_rows [$];
   stim_row_type    event_plan [$];

   int fail_count      = 0;
   int events_sent     = 0;
   int results_checked = 0;
   int burst_left      = 0;
   int gen_ticks;
   logic gen_running;
   logic [9:0] stall_cycle = '0;

   stim_row_type directed_rows [25] = '{
      '{mcbnf_pkg::OP_CLOCK,    0,     1, 0, 0, 0,   0, 0, 0, 1},   // clock while stopped
      '{mcbnf_pkg::OP_STOP,     0,     1, 0, 0, 0,   0, 0, 0, 1},   // stop while stopped
      '{mcbnf_pkg::OP_CONTINUE, 0,     1, 0, 0, 0,   0, 0, 1, 1},
      '{mcbnf_pkg::OP_START,    0,     1, 0, 0, 0,   0, 0, 1, 1},   // start while running
      '{mcbnf_pkg::OP_CLOCK,    0,     1, 0, 1, 100, 0, 0, 1, 2},   // bar 0 straight away
      '{mcbnf_pkg::OP_CLOCK,    0,     1, 1, 0, 0,   0, 0, 1, 3},
      '{mcbnf_pkg::OP_SONGPOS,  15,    0, 0, 0, 0,   0, 0, 0, 0},
      '{mcbnf_pkg::OP_CLOCK,    0,     0, 0, 0, 0,   0, 0, 0, 0},
      '{mcbnf_pkg::OP_CLOCK,    0,     0, 0, 0, 0,   0, 0, 0, 0},
      '{mcbnf_pkg::OP_CLOCK,    0,     0, 0, 0, 0,   0, 0, 0, 0},
      '{mcbnf_pkg::OP_CLOCK,    0,     0, 0, 0, 0,   0, 0, 0, 0},   // bar 1 at the lead
      '{mcbnf_pkg::OP_SONGPOS,  0,     0, 0, 0, 0,   0, 0, 0, 0},   // seek back re-arms bar 0
      '{mcbnf_pkg::OP_SONGPOS,  16383, 0, 0, 0, 0,   0, 0, 0, 0},
      '{mcbnf_pkg::OP_CLOCK,    0,     0, 0, 0, 0,   0, 0, 0, 0},
      '{mcbnf_pkg::OP_CLOCK,    0,     0, 0, 0, 0,   0, 0, 0, 0},
      '{mcbnf_pkg::OP_CLOCK,    0,     0, 0, 0, 0,   0, 0, 0, 0},
      '{mcbnf_pkg::OP_CLOCK,    0,     0, 0, 0, 0,   0, 0, 0, 0},
      '{mcbnf_pkg::OP_STOP,     0,     1, 1, 0, 0,   0, 0, 0, 11},  // stop cuts the note
      '{OP_SPARE_LO,            16383, 1, 0, 0, 0,   0, 0, 0, 11},
      '{OP_SPARE_HI,            0,     1, 0, 0, 0,   0, 0, 0, 11},
      '{mcbnf_pkg::OP_SONGPOS,  8,     0, 0, 0, 0,   0, 0, 0, 0},   // half a bar in, stopped
      '{mcbnf_pkg::OP_CONTINUE, 0,     0, 0, 0, 0,   0, 0, 0, 0},
      '{mcbnf_pkg::OP_STOP,     0,     1, 0, 0, 0,   0, 0, 0, 11},
      '{mcbnf_pkg::OP_START,    0,     0, 0, 0, 0,   0, 0, 0, 0},
      '{mcbnf_pkg::OP_CLOCK,    0,     0, 0, 0, 0,   0, 0, 0, 0}
   };

   task automatic report(input string msg);
      if (fail_count < 100) $display("ERROR: %s", msg);
      fail_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report($sformatf("report %0d: %s is %0h, expected %0h", results_checked, name,
                          got, want));
   endtask

   function automatic void scan_bar(inout note_report_type r);
      int          bar;
      int          target;
      int unsigned into;
      int unsigned lead;
      logic        first;
      logic        emit;
      bar    = int'(fl_ticks / mcbnf_pkg::BAR_TICKS);
      into   = int'(fl_ticks % mcbnf_pkg::BAR_TICKS);
      lead   = (cfg_advance == 4'd0) ? 1 : int'(cfg_advance);
      first  = bar == 0 && fl_last_bar < 0 && fl_ticks < mcbnf_pkg::TICKS_PER_QUARTER;
      emit   = first || (bar + 1 > fl_last_bar && mcbnf_pkg::BAR_TICKS - into <= lead);
      target = first ? bar : bar + 1;
      if (emit) begin
         fl_last_bar = target;
         r.quarters  = 20'(target * 4);
      end
      // note-off only in the first tenth of the bar, never on its downbeat
      if (fl_sounding && into > 0 && into * 10 < mcbnf_pkg::BAR_TICKS) begin
         r.note_off  = 1'b1;
         fl_sounding = 1'b0;
      end
      if (emit) begin
         r.note_on   = 1'b1;
         fl_sounding = 1'b1;
      end
   endfunction

   function automatic note_report_type follow_event(input logic [2:0] op,
                                                    input logic [13:0] sp);
      note_report_type r;
      longint          old_ticks;
      longint          new_ticks;
      int              bar;
      r = '0;
      case (op)
         mcbnf_pkg::OP_CLOCK: begin
            fl_clocks = fl_clocks + 32'd1;
            if (fl_running) begin
               if (longint'(fl_ticks) < COUNT_MAX) fl_ticks = fl_ticks + 1'b1;
               scan_bar(r);
            end
         end
         mcbnf_pkg::OP_START: begin
            if (!fl_running) begin
               fl_ticks    = '0;
               fl_last_bar = -1;
               fl_running  = 1'b1;
            end
         end
         mcbnf_pkg::OP_STOP: begin
            if (fl_running) begin
               r.note_off  = fl_sounding;
               fl_sounding = 1'b0;
               fl_ticks    = '0;
               fl_last_bar = -1;
               fl_running  = 1'b0;
            end
         end
         mcbnf_pkg::OP_CONTINUE: begin
            if (!fl_running) begin
               fl_last_bar = int'(fl_ticks / mcbnf_pkg::BAR_TICKS) - 1;
               fl_running  = 1'b1;
            end
         end
         mcbnf_pkg::OP_SONGPOS: begin
            old_ticks = longint'(fl_ticks);
            new_ticks = longint'(sp) * mcbnf_pkg::SIXTEENTH_TICKS;
            if (new_ticks > COUNT_MAX) new_ticks = COUNT_MAX;
            fl_ticks = new_ticks[mcbnf_pkg::COUNT_BITS_DEF-1:0];
            // re-arm when stopped or on a real seek backwards
            if (!fl_running
                || new_ticks + mcbnf_pkg::TICKS_PER_QUARTER / 2 < old_ticks) begin
               bar = int'(fl_ticks / mcbnf_pkg::BAR_TICKS);
               fl_last_bar = (fl_ticks % mcbnf_pkg::BAR_TICKS
                              < 2 * mcbnf_pkg::TICKS_PER_QUARTER) ? bar - 1 : bar;
            end
            if (fl_running) scan_bar(r);
         end
         default: ;
      endcase
      r.channel  = cfg_channel;
      r.note     = cfg_note;
      r.velocity = r.note_on ? cfg_velocity : 7'd0;
      r.position = 22'(fl_ticks / mcbnf_pkg::SIXTEENTH_TICKS);
      r.running  = fl_running;
      r.clocks   = fl_clocks;
      return r;
   endfunction

   function automatic void apply_setting(input logic [1:0] index, input logic [6:0] data);
      case (index)
         mcbnf_pkg::CSR_ADVANCE:  cfg_advance  = data[3:0];
         mcbnf_pkg::CSR_CHANNEL:  cfg_channel  = data[3:0];
         mcbnf_pkg::CSR_NOTE:     cfg_note     = data;
         mcbnf_pkg::CSR_VELOCITY: cfg_velocity = data;
         default: ;
      endcase
   endfunction

   // scoreboard: results first, then the new transaction, then settings
   always @(posedge clock) begin
      note_report_type want;
      stim_row_type    row;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_reports.size() == 0) begin
               report($sformatf("report %0d arrived with nothing expected", results_checked));
            end else begin
               want = expected_reports.pop_front();
               check_field("note_off_sent", 32'(rsp_if.note_off_sent), 32'(want.note_off));
               check_field("note_on_sent", 32'(rsp_if.note_on_sent), 32'(want.note_on));
               check_field("out_channel", 32'(rsp_if.out_channel), 32'(want.channel));
               check_field("out_note", 32'(rsp_if.out_note), 32'(want.note));
               check_field("out_velocity", 32'(rsp_if.out_velocity), 32'(want.velocity));
               check_field("beat_quarter_count", 32'(rsp_if.beat_quarter_count),
                           32'(want.quarters));
               check_field("position_sixteenths", 32'(rsp_if.position_sixteenths),
                           32'(want.position));
               check_field("is_running", 32'(rsp_if.is_running), 32'(want.running));
               check_field("clocks_received", rsp_if.clocks_received, want.clocks);
            end
            results_checked++;
         end
         if (req_if.valid && req_if.ready) begin
            row  = pinned_rows.pop_front();
            want = follow_event(req_if.opcode, req_if.song_position);
            if (row.pinned) begin
               want.note_off = row.off;
               want.note_on  = row.on;
               want.velocity = row.vel;
               want.quarters = row.quarters;
               want.position = row.position;
               want.running  = row.running;
               want.clocks   = row.clocks;
            end
            expected_reports.push_back(want);
         end
         if (csr_if.valid && csr_if.ready) apply_setting(csr_if.index, csr_if.wdata);
      end
   end

   // receiver back-pressure, in four modes picked by bits 8:7 of the stall counter
   always @(posedge clock) begin
      stall_cycle <= stall_cycle + 10'd1;
      case (stall_cycle[8:7])
         2'd0:    rsp_if.ready <= 1'b1;
         2'd1:    rsp_if.ready <= ($urandom_range(0, 3) != 0);
         2'd2:    rsp_if.ready <= (stall_cycle[1:0] != 2'd3);
         default: rsp_if.ready <= 1'($urandom_range(0, 1));
      endcase
   end

   task automatic drive_event(input stim_row_type row);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_if.valid  <= 1'b0;
            req_if.opcode <= 3'($urandom);
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      pinned_rows.push_back(row);
      req_if.valid         <= 1'b1;
      req_if.opcode        <= row.op;
      req_if.song_position <= row.sp;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      events_sent++;
   endtask

   task automatic write_setting(input logic [1:0] index, input logic [6:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= index;
      csr_if.wdata <= data;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      while (results_checked < events_sent) @(posedge clock);
   endtask

   // the plan keeps its own rough view of the position to aim seeks
   task automatic schedule_event(input logic [2:0] op, input logic [13:0] sp);
      stim_row_type row;
      row    = '0;
      row.op = op;
      row.sp = sp;
      event_plan.push_back(row);
      case (op)
         mcbnf_pkg::OP_CLOCK:    if (gen_running) gen_ticks++;
         mcbnf_pkg::OP_START: begin
            if (!gen_running) gen_ticks = 0;
            gen_running = 1'b1;
         end
         mcbnf_pkg::OP_STOP: begin
            gen_ticks   = 0;
            gen_running = 1'b0;
         end
         mcbnf_pkg::OP_CONTINUE: gen_running = 1'b1;
         mcbnf_pkg::OP_SONGPOS:  gen_ticks = int'(sp) * mcbnf_pkg::SIXTEENTH_TICKS;
         default: ;
      endcase
   endtask

   function automatic logic [13:0] seek_target();
      int cur;
      int base;
      int pick;
      cur  = gen_ticks / mcbnf_pkg::SIXTEENTH_TICKS;
      base = (cur / 16) * 16;
      case ($urandom_range(0, 4))
         0:       pick = int'($urandom_range(0, SONGPOS_MAX));
         1:       pick = base + int'($urandom_range(13, 15));  // just short of the next bar
         2:       pick = cur - 2;                               // about 12 ticks back
         3:       pick = cur - 3;
         default: pick = base + int'($urandom_range(6, 9));    // around half a bar
      endcase
      if (pick < 0) pick = 0;
      if (pick > SONGPOS_MAX) pick = SONGPOS_MAX;
      return 14'(pick);
   endfunction

   task automatic build_plan(input int target);
      int roll;
      event_plan.delete();
      gen_ticks   = int'(fl_ticks);
      gen_running = fl_running;
      while (event_plan.size() < target) begin
         repeat ($urandom_range(0, 2)) schedule_event(mcbnf_pkg::OP_CLOCK, 14'($urandom));
         if ($urandom_range(0, 9) < 7) begin
            schedule_event(mcbnf_pkg::OP_START, 14'($urandom));
         end else begin
            schedule_event(mcbnf_pkg::OP_SONGPOS, seek_target());
            schedule_event(mcbnf_pkg::OP_CONTINUE, 14'($urandom));
         end
         repeat ($urandom_range(10, 220)) begin
            roll = $urandom_range(0, 99);
            if (roll < 87) begin
               schedule_event(mcbnf_pkg::OP_CLOCK, 14'($urandom));
            end else if (roll < 94) begin
               schedule_event(mcbnf_pkg::OP_SONGPOS, seek_target());
            end else if (roll < 97) begin
               schedule_event(mcbnf_pkg::OP_STOP, 14'($urandom));
               schedule_event(mcbnf_pkg::OP_CONTINUE, 14'($urandom));
            end else begin
               schedule_event(3'($urandom), 14'($urandom));
            end
         end
         if ($urandom_range(0, 9) != 0) schedule_event(mcbnf_pkg::OP_STOP, 14'($urandom));
      end
      while (event_plan.size() > target) void'(event_plan.pop_back());
   endtask

   initial begin
      logic [6:0] set_advance;
      logic [6:0] set_channel;
      logic [6:0] set_note;
      logic [6:0] set_velocity;
      reset                = 1'b1;
      req_if.valid         = 1'b0;
      req_if.opcode        = mcbnf_pkg::OP_CLOCK;
      req_if.song_position = '0;
      rsp_if.ready         = 1'b0;
      csr_if.valid         = 1'b0;
      csr_if.index         = mcbnf_pkg::CSR_ADVANCE;
      csr_if.wdata         = '0;
      fl_running   = 1'b0;
      fl_ticks     = '0;
      fl_last_bar  = -1;
      fl_sounding  = 1'b0;
      fl_clocks    = '0;
      cfg_advance  = mcbnf_pkg::ADVANCE_RST;
      cfg_channel  = mcbnf_pkg::CHANNEL_RST;
      cfg_note     = mcbnf_pkg::NOTE_RST;
      cfg_velocity = mcbnf_pkg::VELOCITY_RST;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) drive_event(directed_rows[i]);
      req_if.valid <= 1'b0;
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               // zero lead acts as one tick; channel write carries spare high bits
               set_advance  = 7'd0;
               set_channel  = 7'h7F;
               set_note     = 7'd127;
               set_velocity = 7'd127;
            end
            1: begin
               set_advance  = 7'd15;
               set_channel  = 7'd0;
               set_note     = 7'd0;
               set_velocity = 7'd0;
            end
            default: begin
               set_advance  = 7'($urandom);
               set_channel  = 7'($urandom);
               set_note     = 7'($urandom);
               set_velocity = 7'($urandom);
            end
         endcase
         write_setting(mcbnf_pkg::CSR_ADVANCE, set_advance);
         write_setting(mcbnf_pkg::CSR_CHANNEL, set_channel);
         write_setting(mcbnf_pkg::CSR_NOTE, set_note);
         write_setting(mcbnf_pkg::CSR_VELOCITY, set_velocity);
         csr_if.valid <= 1'b0;
         build_plan(285);
         foreach (event_plan[i]) drive_event(event_plan[i]);
         req_if.valid <= 1'b0;
         wait_drained();
      end

      repeat (4) @(posedge clock);
      if (expected_reports.size() != 0)
         report($sformatf("%0d reports never arrived", expected_reports.size()));
      if (fail_count == 0) begin
         $display("midi_clock_bar_note_follower_top regression: pass");
      end else begin
         $display("midi_clock_bar_note_follower_top regression: fail");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("midi_clock_bar_note_follower_top regression: fail");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+design
design/mcbnf_pkg.sv
design/mcbnf_if.sv
design/mcbnf_tracker.sv
design/midi_clock_bar_note_follower_top.sv
tb/tb.sv
